@@ rtl/lpf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lamp persistence filter package
// Shared sizes, register indexes, reset values and item types.
// ----------------------------------------------------------------------------
package lpf_pkg;

    localparam int ROWS       = 7;
    localparam int COLS       = 18;

    localparam int ROW_W      = 3;
    localparam int LIGHTS_W   = 18;
    localparam int COL_W      = 5;
    localparam int LEVEL_W    = 5;
    localparam int WIN_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int INT_W      = 16;
    localparam int CNT_W      = 8;
    localparam int T_W        = INT_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int LAMPS      = ROWS * COLS;
    localparam int ROW_AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_AW     = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int LAMP_AW    = (LAMPS > 1) ? $clog2(LAMPS) : 1;
    localparam int CNT_WORD_W = COLS * CNT_W + CNT_W;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RISE_GAIN     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR  = CFG_IDX_W'(2);

    localparam logic [WIN_W-1:0]  WIN_RESET   = WIN_W'(100);
    localparam logic [GAIN_W-1:0] RISE_RESET  = GAIN_W'(786);
    localparam logic [GAIN_W-1:0] DECAY_RESET = GAIN_W'(65208);

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [LIGHTS_W-1:0] lights_word;
    } in_t;

    typedef struct packed {
        logic [ROW_W-1:0]   out_row;
        logic [COL_W-1:0]   column;
        logic [LEVEL_W-1:0] level;
        logic               last;
    } out_t;

    typedef struct packed {
        logic [WIN_W-1:0]  sample_window;
        logic [GAIN_W-1:0] rise_gain;
        logic [GAIN_W-1:0] decay_factor;
    } cfg_t;

endpackage
`default_nettype wire

@@ rtl/lpf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/lpf_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// On-fraction divider
// Serial restoring division giving round(count / window) in Q1.16, one
// quotient bit per cycle, saturated to 1.0.
// ----------------------------------------------------------------------------
module lpf_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [lpf_pkg::CNT_W-1:0]  count,
    input  wire logic [lpf_pkg::WIN_W-1:0]  win,
    output logic                            done,
    output logic      [lpf_pkg::T_W-1:0]    quot
);

    localparam int STEP_W = $clog2(lpf_pkg::INT_W);

    logic                        busy_reg;
    logic                        done_reg;
    logic                        sat_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [lpf_pkg::WIN_W-1:0]   win_reg;
    logic [lpf_pkg::WIN_W-1:0]   rem_reg;
    logic [lpf_pkg::INT_W-1:0]   low_reg;
    logic [lpf_pkg::INT_W-1:0]   q_reg;

    logic [lpf_pkg::WIN_W:0]     shifted;
    logic                        ge;
    logic [lpf_pkg::WIN_W-1:0]   rem_next;
    logic                        saturate;

    // The dividend is count * 2^16 + window / 2. A count at or above the
    // window gives at least 1.0, so only counts below it are divided, and then
    // the remainder always stays below the window.
    assign saturate = (count >= win);
    assign shifted  = {rem_reg, low_reg[lpf_pkg::INT_W-1]};
    assign ge       = (shifted >= {1'b0, win_reg});
    assign rem_next = ge ? lpf_pkg::WIN_W'(shifted - {1'b0, win_reg})
                         : lpf_pkg::WIN_W'(shifted);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= !saturate;
            done_reg <= saturate;
        end else if (busy_reg && step_reg == STEP_W'(lpf_pkg::INT_W - 1)) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sat_reg  <= saturate;
            step_reg <= '0;
            win_reg  <= win;
            rem_reg  <= count;
            low_reg  <= lpf_pkg::INT_W'(win >> 1);
            q_reg    <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + STEP_W'(1);
            rem_reg  <= rem_next;
            low_reg  <= {low_reg[lpf_pkg::INT_W-2:0], 1'b0};
            q_reg    <= {q_reg[lpf_pkg::INT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = sat_reg ? {1'b1, {lpf_pkg::INT_W{1'b0}}} : {1'b0, q_reg};

endmodule
`default_nettype wire

@@ rtl/lpf_glow.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Glow update datapath
// Three registered stages: rise or decay product, rounded new intensity,
// and the displayed level of that intensity.
// ----------------------------------------------------------------------------
module lpf_glow (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [lpf_pkg::T_W-1:0]      t,
    input  wire logic [lpf_pkg::INT_W-1:0]    cur,
    input  wire lpf_pkg::cfg_t                cfg,
    output logic                              done,
    output logic      [lpf_pkg::INT_W-1:0]    v,
    output logic      [lpf_pkg::LEVEL_W-1:0]  level
);

    localparam int PROD_W = lpf_pkg::T_W + lpf_pkg::GAIN_W;
    localparam int F      = lpf_pkg::INT_W;
    localparam int SH_W   = PROD_W + 1 - F;
    localparam int LV_W   = lpf_pkg::INT_W + lpf_pkg::LEVEL_W + 1;

    logic                         v1_reg, v2_reg, v3_reg;
    logic [PROD_W-1:0]            prod_reg;
    logic                         rise_reg;
    logic [lpf_pkg::INT_W-1:0]    cur_reg;
    logic [lpf_pkg::INT_W-1:0]    v_reg;
    logic [lpf_pkg::LEVEL_W-1:0]  level_reg;

    logic                         rise;
    logic [lpf_pkg::T_W-1:0]      mul_a;
    logic [lpf_pkg::GAIN_W-1:0]   mul_b;
    logic [PROD_W-1:0]            prod;
    logic [PROD_W:0]              rnd;
    logic [SH_W-1:0]              sh;
    logic [SH_W-1:0]              sum;
    logic [lpf_pkg::INT_W-1:0]    v_new;
    logic [LV_W-1:0]              lv;

    // One multiplier serves both cases: the gap times the rise gain, or the
    // intensity times the decay factor.
    assign rise  = (t >= lpf_pkg::T_W'(cur));
    assign mul_a = rise ? (t - lpf_pkg::T_W'(cur)) : lpf_pkg::T_W'(cur);
    assign mul_b = rise ? cfg.rise_gain : cfg.decay_factor;
    assign prod  = mul_a * mul_b;

    assign rnd = {1'b0, prod_reg} + (PROD_W + 1)'(1 << (F - 1));
    assign sh  = rnd[PROD_W:F];
    assign sum = SH_W'(cur_reg) + sh;

    always_comb begin
        if (rise_reg) begin
            if (sum > SH_W'({lpf_pkg::INT_W{1'b1}})) begin
                v_new = {lpf_pkg::INT_W{1'b1}};
            end else begin
                v_new = sum[lpf_pkg::INT_W-1:0];
            end
        end else begin
            v_new = sh[lpf_pkg::INT_W-1:0];
        end
    end

    // Full scale is 2^LEVEL_W - 1, so the product is a shift and a subtract.
    assign lv = ({LV_W'(v_reg)} << lpf_pkg::LEVEL_W) - LV_W'(v_reg)
              + LV_W'(1 << (F - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= prod;
            rise_reg <= rise;
            cur_reg  <= cur;
        end
        if (v1_reg) begin
            v_reg <= v_new;
        end
        if (v2_reg) begin
            level_reg <= lv[F +: lpf_pkg::LEVEL_W];
        end
    end

    assign done  = v3_reg;
    assign v     = v_reg;
    assign level = level_reg;

endmodule
`default_nettype wire

@@ rtl/lamp_persistence_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lamp persistence filter
// A sample that completes no window is a count read, then an update.
// One that completes a window walks the row lamp by lamp (the 16-step
// divider is skipped where the count fills the window) and waits on any
// output stall; no new item is taken before the walk ends.
// Synchronous reset restores the register defaults; unwritten rows read as 0.
// ----------------------------------------------------------------------------
module lamp_persistence_filter (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire lpf_pkg::in_t                      s_item,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output lpf_pkg::out_t                          m_item,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lpf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lpf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CNT_MOD,
        S_LAMP_RD,
        S_LAMP_CUR,
        S_DIV_WAIT,
        S_GLOW_WAIT,
        S_EMIT
    } state_t;

    typedef logic [lpf_pkg::COLS-1:0][lpf_pkg::CNT_W-1:0] counts_t;

    state_t                          state_reg;
    logic                            m_valid_reg;
    lpf_pkg::out_t                   m_item_reg;
    lpf_pkg::cfg_t                   cfg_reg;
    logic [lpf_pkg::ROWS-1:0]        cnt_vld_reg;
    logic [lpf_pkg::ROWS-1:0]        int_vld_reg;

    logic [lpf_pkg::ROW_W-1:0]       row_reg;
    logic [lpf_pkg::COLS-1:0]        lit_reg;
    counts_t                         counts_reg;
    logic [lpf_pkg::LAMP_AW-1:0]     lamp_addr_reg;
    logic [lpf_pkg::COL_AW-1:0]      col_reg;
    logic [lpf_pkg::INT_W-1:0]       cur_reg;

    logic                            in_acc;
    logic                            row_ok;
    logic                            out_free;
    logic                            last_col;
    logic [lpf_pkg::ROW_AW-1:0]      row_addr;
    logic [lpf_pkg::LAMP_AW-1:0]     row_base;
    logic [lpf_pkg::WIN_W-1:0]       win_eff;

    logic                            cnt_re;
    logic                            cnt_we;
    logic [lpf_pkg::CNT_WORD_W-1:0]  cnt_rdata;
    logic [lpf_pkg::CNT_WORD_W-1:0]  cnt_old;
    logic [lpf_pkg::CNT_WORD_W-1:0]  cnt_wdata;
    counts_t                         cnt_old_counts;
    counts_t                         cnt_new;
    logic [lpf_pkg::CNT_W-1:0]       rc_new;
    logic                            fire;

    logic                            int_re;
    logic                            int_we;
    logic [lpf_pkg::INT_W-1:0]       int_rdata;

    logic                            div_start;
    logic                            div_done;
    logic [lpf_pkg::T_W-1:0]         div_quot;

    logic                            glow_start;
    logic                            glow_done;
    logic [lpf_pkg::INT_W-1:0]       glow_v;
    logic [lpf_pkg::LEVEL_W-1:0]     glow_level;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    assign in_acc   = s_valid && s_ready;
    assign row_ok   = (int'(s_item.row) < lpf_pkg::ROWS);
    assign out_free = !m_valid_reg || m_ready;
    assign last_col = (col_reg == lpf_pkg::COL_AW'(lpf_pkg::COLS - 1));
    assign row_addr = lpf_pkg::ROW_AW'(row_reg);
    assign row_base = lpf_pkg::LAMP_AW'(int'(row_reg) * lpf_pkg::COLS);
    assign win_eff  = (cfg_reg.sample_window == '0) ? lpf_pkg::WIN_W'(1)
                                                    : cfg_reg.sample_window;

    // Count memory: one word per row, the lamp counts with the row's sample
    // count on top. A row never written reads as zero.
    assign cnt_re = in_acc;
    assign cnt_we = (state_reg == S_CNT_MOD);
    assign cnt_old = cnt_vld_reg[row_addr] ? cnt_rdata : '0;
    assign cnt_old_counts = cnt_old[lpf_pkg::COLS*lpf_pkg::CNT_W-1:0];
    assign rc_new = cnt_old[lpf_pkg::COLS*lpf_pkg::CNT_W +: lpf_pkg::CNT_W]
                  + lpf_pkg::CNT_W'(1);
    assign fire   = (rc_new >= win_eff);

    always_comb begin
        for (int c = 0; c < lpf_pkg::COLS; c++) begin
            cnt_new[c] = cnt_old_counts[c] + lpf_pkg::CNT_W'(lit_reg[c]);
        end
    end

    // A completed window restarts the row's counters at once; the counts
    // themselves are held in counts_reg for the lamp walk.
    assign cnt_wdata = fire ? '0 : {rc_new, cnt_new};

    lpf_ram #(
        .WIDTH (lpf_pkg::CNT_WORD_W),
        .DEPTH (lpf_pkg::ROWS)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (row_addr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (lpf_pkg::ROW_AW'(s_item.row)),
        .rdata (cnt_rdata)
    );

    assign int_re = (state_reg == S_LAMP_RD);
    assign int_we = (state_reg == S_GLOW_WAIT) && glow_done;

    lpf_ram #(
        .WIDTH (lpf_pkg::INT_W),
        .DEPTH (lpf_pkg::LAMPS)
    ) u_int_ram (
        .aclk  (aclk),
        .we    (int_we),
        .waddr (lamp_addr_reg),
        .wdata (glow_v),
        .re    (int_re),
        .raddr (lamp_addr_reg),
        .rdata (int_rdata)
    );

    assign div_start = (state_reg == S_LAMP_RD);

    lpf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .count   (counts_reg[col_reg]),
        .win     (win_eff),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign glow_start = (state_reg == S_DIV_WAIT) && div_done;

    lpf_glow u_glow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (glow_start),
        .t       (div_quot),
        .cur     (cur_reg),
        .cfg     (cfg_reg),
        .done    (glow_done),
        .v       (glow_v),
        .level   (glow_level)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg                 <= S_IDLE;
            m_valid_reg               <= 1'b0;
            cnt_vld_reg               <= '0;
            int_vld_reg               <= '0;
            cfg_reg.sample_window     <= lpf_pkg::WIN_RESET;
            cfg_reg.rise_gain         <= lpf_pkg::RISE_RESET;
            cfg_reg.decay_factor      <= lpf_pkg::DECAY_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    lpf_pkg::REG_SAMPLE_WINDOW: begin
                        cfg_reg.sample_window <= cfg_data[lpf_pkg::WIN_W-1:0];
                    end
                    lpf_pkg::REG_RISE_GAIN: begin
                        cfg_reg.rise_gain <= cfg_data[lpf_pkg::GAIN_W-1:0];
                    end
                    lpf_pkg::REG_DECAY_FACTOR: begin
                        cfg_reg.decay_factor <= cfg_data[lpf_pkg::GAIN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            // In the emit state a taken item is replaced by the next one below.
            if (m_valid_reg && m_ready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc && row_ok) begin
                        state_reg <= S_CNT_MOD;
                    end
                end
                S_CNT_MOD: begin
                    cnt_vld_reg[row_addr] <= 1'b1;
                    state_reg <= fire ? S_LAMP_RD : S_IDLE;
                end
                S_LAMP_RD: begin
                    state_reg <= S_LAMP_CUR;
                end
                S_LAMP_CUR: begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        state_reg <= S_GLOW_WAIT;
                    end
                end
                S_GLOW_WAIT: begin
                    if (glow_done) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if (last_col) begin
                            // Every lamp of the row has now been written.
                            int_vld_reg[row_addr] <= 1'b1;
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= S_LAMP_RD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            row_reg <= s_item.row;
            lit_reg <= lpf_pkg::COLS'(s_item.lights_word);
        end
        if (state_reg == S_CNT_MOD) begin
            counts_reg    <= cnt_new;
            lamp_addr_reg <= row_base;
            col_reg       <= '0;
        end
        // Lamps of the row not yet rewritten in this update read as zero until
        // the row has completed its first update.
        if (state_reg == S_LAMP_CUR) begin
            cur_reg <= int_vld_reg[row_addr] ? int_rdata : '0;
        end
        if (state_reg == S_EMIT && out_free) begin
            m_item_reg.out_row <= row_reg;
            m_item_reg.column  <= lpf_pkg::COL_W'(col_reg);
            m_item_reg.level   <= glow_level;
            m_item_reg.last    <= last_col;
            lamp_addr_reg      <= lamp_addr_reg + lpf_pkg::LAMP_AW'(1);
            col_reg            <= col_reg + lpf_pkg::COL_AW'(1);
        end
    end

    a_int_write_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        int_we |-> ({1'b0, lamp_addr_reg} >= {1'b0, row_base}) &&
                   ({1'b0, lamp_addr_reg} <
                    {1'b0, row_base} + (lpf_pkg::LAMP_AW + 1)'(lpf_pkg::COLS)))
        else $error("intensity write outside the row being updated");

    a_glow_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        glow_done |-> (state_reg == S_GLOW_WAIT))
        else $error("glow result arrived while the sequencer was not waiting");

    a_div_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LAMP_CUR) |=> (state_reg == S_DIV_WAIT) && !glow_done)
        else $error("lamp sequence left the divider wait out of order");

endmodule
`default_nettype wire

@@ tb/tb_lamp_persistence_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lamp persistence filter testbench
// Drives on/off row samples and register writes into the filter, keeps its
// own copy of the per-lamp counters and glow levels, and checks every lamp
// level the block reports, in order, against that copy or a fixed level. A
// short directed table comes first, then several phases of random samples
// under different window, rise and decay settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_lamp_persistence_filter;

    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int RAND_PHASES   = 6;
    localparam int PLAN_LEN      = 27;

    typedef enum logic [1:0] {
        STEP_WRITE,
        STEP_SAMPLE
    } step_kind_t;

    // How the results of a directed sample are obtained.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_QUIET,
        CHK_FLAT
    } check_t;

    typedef struct packed {
        step_kind_t                         kind;
        logic [lpf_pkg::CFG_IDX_W-1:0]      reg_idx;
        logic [lpf_pkg::CFG_DATA_W-1:0]     data;
        logic [lpf_pkg::ROW_W-1:0]          row;
        logic [lpf_pkg::LIGHTS_W-1:0]       word;
        check_t                             check;
        logic [lpf_pkg::LEVEL_W-1:0]        level;
    } plan_step_t;

    // Columns: kind, register, data, row, lights, check, level for every lamp.
    localparam plan_step_t PLAN [PLAN_LEN] = '{
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd0, 18'h3FFFF, CHK_QUIET, 5'd0},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd7, 18'h3FFFF, CHK_QUIET, 5'd0},
        '{STEP_WRITE,  lpf_pkg::REG_SAMPLE_WINDOW, 16'd3, 3'd0, 18'h00000, CHK_QUIET, 5'd0},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd0, 18'h2AAAA, CHK_QUIET, 5'd0},
        '{STEP_WRITE,  lpf_pkg::REG_SAMPLE_WINDOW, 16'd1, 3'd0, 18'h00000, CHK_QUIET, 5'd0},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd0, 18'h15555, CHK_MODEL, 5'd0},
        '{STEP_WRITE,  lpf_pkg::REG_RISE_GAIN, 16'hFFFF, 3'd0, 18'h00000, CHK_QUIET, 5'd0},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd1, 18'h3FFFF, CHK_FLAT, 5'd31},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd6, 18'h3FFFF, CHK_FLAT, 5'd31},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd1, 18'h3FFFF, CHK_FLAT, 5'd31},
        '{STEP_WRITE,  lpf_pkg::REG_DECAY_FACTOR, 16'd0, 3'd0, 18'h00000, CHK_QUIET, 5'd0},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd1, 18'h00000, CHK_FLAT, 5'd0},
        '{STEP_WRITE,  lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd0, 18'h00000, CHK_QUIET, 5'd0},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd6, 18'h00000, CHK_FLAT, 5'd0},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd7, 18'h00000, CHK_QUIET, 5'd0},
        '{STEP_WRITE,  lpf_pkg::REG_SAMPLE_WINDOW, 16'd2, 3'd0, 18'h00000, CHK_QUIET, 5'd0},
        '{STEP_WRITE,  lpf_pkg::REG_RISE_GAIN, 16'h8000, 3'd0, 18'h00000, CHK_QUIET, 5'd0},
        '{STEP_WRITE,  lpf_pkg::REG_DECAY_FACTOR, 16'h8000, 3'd0, 18'h00000, CHK_QUIET, 5'd0},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd3, 18'h00001, CHK_QUIET, 5'd0},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd3, 18'h20000, CHK_MODEL, 5'd0},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd4, 18'h3FFFF, CHK_QUIET, 5'd0},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd4, 18'h3FFFF, CHK_MODEL, 5'd0},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd4, 18'h00000, CHK_QUIET, 5'd0},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd4, 18'h00000, CHK_MODEL, 5'd0},
        '{STEP_WRITE,  lpf_pkg::REG_RISE_GAIN, 16'd0, 3'd0, 18'h00000, CHK_QUIET, 5'd0},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd5, 18'h3FFFF, CHK_QUIET, 5'd0},
        '{STEP_SAMPLE, lpf_pkg::REG_SAMPLE_WINDOW, 16'd0, 3'd5, 18'h3FFFF, CHK_FLAT, 5'd0}
    };

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    lpf_pkg::in_t                   s_item    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    lpf_pkg::out_t                  m_item;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [lpf_pkg::CFG_IDX_W-1:0]  cfg_index = lpf_pkg::REG_SAMPLE_WINDOW;
    logic [lpf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Local copy of the filter state and its registers.
    logic [lpf_pkg::CNT_W-1:0]      lamp_hits   [lpf_pkg::LAMPS];
    logic [lpf_pkg::INT_W-1:0]      glow        [lpf_pkg::LAMPS];
    logic [lpf_pkg::CNT_W-1:0]      row_samples [lpf_pkg::ROWS];
    logic [lpf_pkg::WIN_W-1:0]      win_reg   = lpf_pkg::WIN_RESET;
    logic [lpf_pkg::GAIN_W-1:0]     gain_reg  = lpf_pkg::RISE_RESET;
    logic [lpf_pkg::GAIN_W-1:0]     decay_reg = lpf_pkg::DECAY_RESET;
    lpf_pkg::out_t                  row_report  [lpf_pkg::COLS];

    lpf_pkg::out_t                  levels_due [$];
    lpf_pkg::out_t                  head_due;

    bit                    calm = 1'b0;
    int                    stall_left;
    int                    errors;
    int                    levels_checked;
    int                    samples_sent;
    int                    ignored_rows;
    int                    writes_done;
    int                    cycle_count;

    lamp_persistence_filter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [lpf_pkg::INT_W-1:0] next_glow(
        input logic [lpf_pkg::INT_W-1:0] cur,
        input logic [lpf_pkg::CNT_W-1:0] hits,
        input int win);
        longint frac;
        longint lift;
        longint v;
        frac = ((longint'(hits) << 16) + longint'(win / 2)) / longint'(win);
        // A window lowered mid-count can push the fraction past one.
        if (frac > 65536)
            frac = 65536;
        if (frac >= longint'(cur)) begin
            lift = ((frac - longint'(cur)) * longint'(gain_reg) + 32768) >> 16;
            v = longint'(cur) + lift;
            if (v > 65535)
                v = 65535;
        end else begin
            v = (longint'(cur) * longint'(decay_reg) + 32768) >> 16;
        end
        return v[lpf_pkg::INT_W-1:0];
    endfunction

    // Counts one row sample; fills row_report and returns COLS when the row's
    // window is complete, otherwise returns zero.
    function automatic int advance_lamps(input lpf_pkg::in_t it);
        int base;
        int win;
        logic [lpf_pkg::INT_W-1:0] v;
        if (it.row >= lpf_pkg::ROWS)
            return 0;
        base = int'(it.row) * lpf_pkg::COLS;
        for (int c = 0; c < lpf_pkg::COLS; c++)
            lamp_hits[base + c] = lamp_hits[base + c]
                                + lpf_pkg::CNT_W'(it.lights_word[c]);
        row_samples[it.row] = row_samples[it.row] + 1'b1;
        win = (win_reg == 0) ? 1 : int'(win_reg);
        if (int'(row_samples[it.row]) < win)
            return 0;
        for (int c = 0; c < lpf_pkg::COLS; c++) begin
            v = next_glow(glow[base + c], lamp_hits[base + c], win);
            glow[base + c] = v;
            lamp_hits[base + c] = '0;
            row_report[c] = '{out_row: it.row,
                              column:  lpf_pkg::COL_W'(c),
                              level:   lpf_pkg::LEVEL_W'((longint'(v) * 31 + 32768) >> 16),
                              last:    (c == lpf_pkg::COLS - 1)};
        end
        row_samples[it.row] = '0;
        return lpf_pkg::COLS;
    endfunction

    function automatic void note_mismatch(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        errors++;
        if (errors <= 30)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endfunction

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (levels_due.size() != 0)
            @(posedge aclk);
        // A sample that completes no window may still be in flight.
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [lpf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lpf_pkg::CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            lpf_pkg::REG_SAMPLE_WINDOW: win_reg   = val[lpf_pkg::WIN_W-1:0];
            lpf_pkg::REG_RISE_GAIN:     gain_reg  = val[lpf_pkg::GAIN_W-1:0];
            lpf_pkg::REG_DECAY_FACTOR:  decay_reg = val[lpf_pkg::GAIN_W-1:0];
            default: ;
        endcase
        writes_done++;
    endtask

    task automatic run_sample(input lpf_pkg::in_t it, input check_t chk,
                              input logic [lpf_pkg::LEVEL_W-1:0] flat);
        int gap;
        int n;
        gap = 0;
        if (!calm && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        samples_sent++;
        if (it.row >= lpf_pkg::ROWS)
            ignored_rows++;
        n = advance_lamps(it);
        case (chk)
            CHK_MODEL: begin
                for (int c = 0; c < n; c++)
                    levels_due.push_back(row_report[c]);
            end
            CHK_FLAT: begin
                for (int c = 0; c < lpf_pkg::COLS; c++)
                    levels_due.push_back('{out_row: it.row, column: lpf_pkg::COL_W'(c),
                                           level: flat, last: (c == lpf_pkg::COLS - 1)});
            end
            default: ;
        endcase
    endtask

    // Result side back-pressure in random stall bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_ready    <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (levels_due.size() == 0) begin
                errors++;
                if (errors <= 30)
                    $display("%0t: unexpected lamp level, expected none, got row %0d col %0d level %0d",
                             $time, m_item.out_row, m_item.column, m_item.level);
            end else begin
                head_due = levels_due.pop_front();
                if (m_item.out_row !== head_due.out_row)
                    note_mismatch("out_row", head_due.out_row, m_item.out_row);
                if (m_item.column !== head_due.column)
                    note_mismatch("column", head_due.column, m_item.column);
                if (m_item.level !== head_due.level)
                    note_mismatch("level", head_due.level, m_item.level);
                if (m_item.last !== head_due.last)
                    note_mismatch("last", head_due.last, m_item.last);
            end
            levels_checked++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d lamp levels outstanding", $time,
                     levels_due.size());
            $display("FAIL lamp_persistence_filter");
            $finish;
        end
    end

    initial begin
        lpf_pkg::in_t it;
        int taken;
        int items;
        int lanes;
        int first_row;
        logic [lpf_pkg::WIN_W-1:0]  win;
        logic [lpf_pkg::GAIN_W-1:0] gain;
        logic [lpf_pkg::GAIN_W-1:0] decay;

        for (int i = 0; i < lpf_pkg::LAMPS; i++) begin
            lamp_hits[i] = '0;
            glow[i]      = '0;
        end
        for (int r = 0; r < lpf_pkg::ROWS; r++)
            row_samples[r] = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].kind == STEP_WRITE) begin
                write_reg(PLAN[i].reg_idx, PLAN[i].data);
            end else begin
                it.row         = PLAN[i].row;
                it.lights_word = PLAN[i].word;
                run_sample(it, PLAN[i].check, PLAN[i].level);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            // The first phase fills the widest window on a single row.
            if (ph == 0) begin
                win   = 8'd255;
                gain  = 16'hFFFF;
                decay = 16'hFFFF;
                lanes = 1;
                items = 256;
            end else begin
                win   = (ph == 1) ? 8'd1 : (ph == 2) ? 8'd0
                                         : lpf_pkg::WIN_W'($urandom_range(2, 9));
                case ($urandom_range(0, 3))
                    0:       gain = '0;
                    1:       gain = '1;
                    default: gain = lpf_pkg::GAIN_W'($urandom);
                endcase
                case ($urandom_range(0, 3))
                    0:       decay = '0;
                    1:       decay = '1;
                    default: decay = lpf_pkg::GAIN_W'($urandom);
                endcase
                lanes = $urandom_range(1, lpf_pkg::ROWS);
                items = 32;
            end
            first_row = $urandom_range(0, lpf_pkg::ROWS - lanes);
            write_reg(lpf_pkg::REG_SAMPLE_WINDOW, lpf_pkg::CFG_DATA_W'(win));
            write_reg(lpf_pkg::REG_RISE_GAIN, gain);
            write_reg(lpf_pkg::REG_DECAY_FACTOR, decay);
            calm  = (ph == RAND_PHASES - 1);
            taken = 0;
            while (taken < items) begin
                if ($urandom_range(0, 11) == 0)
                    it.row = lpf_pkg::ROW_W'(7);
                else
                    it.row = lpf_pkg::ROW_W'(first_row + $urandom_range(0, lanes - 1));
                case ($urandom_range(0, 3))
                    0:       it.lights_word = '0;
                    1:       it.lights_word = '1;
                    default: it.lights_word = lpf_pkg::LIGHTS_W'($urandom);
                endcase
                run_sample(it, CHK_MODEL, '0);
                if (it.row < lpf_pkg::ROWS)
                    taken++;
            end
        end

        wait_idle();
        if (levels_due.size() != 0)
            errors++;

        $display("Sent %0d row samples (%0d to rows outside the panel) and %0d register writes;",
                 samples_sent, ignored_rows, writes_done);
        $display("checked %0d lamp levels over windows from 0 to 255.", levels_checked);
        if (errors == 0) begin
            $display("PASS lamp_persistence_filter");
        end else begin
            $display("FAIL lamp_persistence_filter");
        end
        $finish;
    end

endmodule
